// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("invariant check failed");
// consequent holds in the same cycle
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// consequent holds in the next cycle
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CHK_ALWAYS(lbl, clk, rst, prop)
`define CHK_IMPL(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fftr2_pkg.sv =====
package fftr2_pkg;

  // default sizes
  localparam int LOG2_MAX_POINTS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int TWIDDLE_BITS_DEF    = 16;

  // fixed field widths
  localparam int STORE_BITS      = 27;
  localparam int BIN_BITS        = 10;
  localparam int CFG_BITS        = 4;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int SIZE_LOG2_RESET = 10;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE_MODE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_LOG2    = 1'b1;

  // input beat kinds
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  // store write source
  typedef enum logic [1:0] {
    WSEL_LOAD = 2'd0,
    WSEL_BF_K = 2'd1,
    WSEL_BF_J = 2'd2
  } wsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsel_t wr_sel;
    logic  tw_en;
    logic  mul_en;
    logic  sum_en;
    logic  inv;
  } dp_cmd_t;

  localparam logic [63:0] PI_Q32 = 64'd13493037705;

  // q30 sine and cosine of an octant phase, packed {sin, cos}
  function automatic logic [127:0] sincos_oct(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    x  = (r * PI_Q32 + (64'd1 << 32)) >> 33;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = signed'(x);
    cs = 64'sd1 <<< 30;
    for (int n = 1; n <= 6; n++) begin
      ts = (ts * x2) >> 30;
      tc = (tc * x2) >> 30;
      case (n)
        1: begin ts = ts / 6;   tc = tc / 2;   end
        2: begin ts = ts / 20;  tc = tc / 12;  end
        3: begin ts = ts / 42;  tc = tc / 30;  end
        4: begin ts = ts / 72;  tc = tc / 56;  end
        5: begin ts = ts / 110; tc = tc / 90;  end
        default: begin ts = ts / 156; tc = tc / 132; end
      endcase
      if ((n % 2) == 1) begin
        ss = ss - signed'(ts);
        cs = cs - signed'(tc);
      end else begin
        ss = ss + signed'(ts);
        cs = cs + signed'(tc);
      end
    end
    return {ss, cs};
  endfunction

  // round q30 to frac bits and saturate
  function automatic logic signed [63:0] quant_tw(input logic signed [63:0] v,
                                                  input int frac);
    logic signed [63:0] q;
    logic signed [63:0] hi;
    int                 sh;
    sh = 30 - frac;
    q  = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    hi = (64'sd1 <<< frac) - 64'sd1;
    if (q > hi) q = hi;
    if (q < -hi - 64'sd1) q = -hi - 64'sd1;
    return q;
  endfunction

  // twiddle table entry k, packed {sin[31:0], cos[31:0]}
  function automatic logic [63:0] tw_word(input int k, input int lmax, input int twb);
    logic [63:0]        pw;
    logic [31:0]        p;
    logic [29:0]        r;
    logic [127:0]       sc;
    logic signed [63:0] s0;
    logic signed [63:0] c0;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] sq;
    logic signed [63:0] cq;
    pw = 64'(k) << (32 - lmax);
    p  = pw[31:0];
    r  = p[29:0];
    if ({34'd0, r} <= (64'd1 << 29)) begin
      sc = sincos_oct({34'd0, r});
      s0 = sc[127:64];
      c0 = sc[63:0];
    end else begin
      sc = sincos_oct((64'd1 << 30) - {34'd0, r});
      c0 = sc[127:64];
      s0 = sc[63:0];
    end
    if (p[30]) begin
      s = c0;
      c = -s0;
    end else begin
      s = s0;
      c = c0;
    end
    sq = quant_tw(s, twb - 1);
    cq = quant_tw(c, twb - 1);
    return {sq[31:0], cq[31:0]};
  endfunction

endpackage

// ===== rtl/fftr2_ram.sv =====
module fftr2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fftr2_tw_rom.sv =====
module fftr2_tw_rom #(
  parameter int LOG2_MAX_POINTS = fftr2_pkg::LOG2_MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS    = fftr2_pkg::TWIDDLE_BITS_DEF,
  parameter int TAW             = (LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS - 1 : 1
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [TAW-1:0]                 addr,
  output logic signed [TWIDDLE_BITS-1:0] cos_q,
  output logic signed [TWIDDLE_BITS-1:0] sin_q
);
  import fftr2_pkg::*;

  localparam int DEPTH = 1 << (LOG2_MAX_POINTS - 1);

  logic [2*TWIDDLE_BITS-1:0] rom [DEPTH];

  // zero-to-half-turn table, {sin, cos}, filled at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam logic [63:0] W = tw_word(g, LOG2_MAX_POINTS, TWIDDLE_BITS);
    assign rom[g] = {W[32 +: TWIDDLE_BITS], W[0 +: TWIDDLE_BITS]};
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {sin_q, cos_q} <= rom[addr];
    end
  end

endmodule

// ===== rtl/fftr2_datapath.sv =====
module fftr2_datapath #(
  parameter int LOG2_MAX_POINTS = fftr2_pkg::LOG2_MAX_POINTS_DEF,
  parameter int SAMPLE_BITS     = fftr2_pkg::SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS    = fftr2_pkg::TWIDDLE_BITS_DEF,
  parameter int TAW             = (LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS - 1 : 1,
  parameter int LW              = $clog2(LOG2_MAX_POINTS + 1)
) (
  input  logic                                   clk,
  input  fftr2_pkg::dp_cmd_t                     cmd,
  input  logic [LOG2_MAX_POINTS-1:0]             rd_addr,
  input  logic [LOG2_MAX_POINTS-1:0]             wr_addr,
  input  logic [TAW-1:0]                         tw_addr,
  input  logic [LW-1:0]                          out_shift,
  input  logic signed [SAMPLE_BITS-1:0]          sample_re,
  input  logic signed [SAMPLE_BITS-1:0]          sample_im,
  output logic signed [fftr2_pkg::STORE_BITS-1:0] out_re,
  output logic signed [fftr2_pkg::STORE_BITS-1:0] out_im
);
  import fftr2_pkg::*;

  localparam int F  = TWIDDLE_BITS - 1;
  localparam int PW = TWIDDLE_BITS + 1 + STORE_BITS;
  localparam logic signed [PW+1:0] RND = (PW+2)'(1) <<< (F - 1);

  logic [2*STORE_BITS-1:0]       ram_q;
  logic [2*STORE_BITS-1:0]       ram_d;
  logic signed [TWIDDLE_BITS-1:0] cos_q;
  logic signed [TWIDDLE_BITS-1:0] sin_q;
  logic signed [TWIDDLE_BITS:0]   wr_ext;
  logic signed [TWIDDLE_BITS:0]   wi_ext;
  logic signed [STORE_BITS-1:0]   q_re;
  logic signed [STORE_BITS-1:0]   q_im;
  logic signed [PW-1:0]           p_rr;
  logic signed [PW-1:0]           p_ii;
  logic signed [PW-1:0]           p_ri;
  logic signed [PW-1:0]           p_ir;
  logic signed [PW+1:0]           sum_re;
  logic signed [PW+1:0]           sum_im;
  logic signed [STORE_BITS-1:0]   t_re;
  logic signed [STORE_BITS-1:0]   t_im;
  logic signed [STORE_BITS-1:0]   xj_re;
  logic signed [STORE_BITS-1:0]   xj_im;
  logic signed [STORE_BITS-1:0]   d_re;
  logic signed [STORE_BITS-1:0]   d_im;

  // frame store, {re, im} per word
  fftr2_ram #(
    .WIDTH (2 * STORE_BITS),
    .DEPTH (1 << LOG2_MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (ram_d),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  fftr2_tw_rom #(
    .LOG2_MAX_POINTS (LOG2_MAX_POINTS),
    .TWIDDLE_BITS    (TWIDDLE_BITS),
    .TAW             (TAW)
  ) u_tw_rom (
    .clk   (clk),
    .rd_en (cmd.tw_en),
    .addr  (tw_addr),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  assign q_re = ram_q[2*STORE_BITS-1:STORE_BITS];
  assign q_im = ram_q[STORE_BITS-1:0];

  // forward uses the conjugate twiddle
  assign wr_ext = (TWIDDLE_BITS+1)'(cos_q);
  assign wi_ext = cmd.inv ? (TWIDDLE_BITS+1)'(sin_q) : -(TWIDDLE_BITS+1)'(sin_q);

  // complex multiply, one register per product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rr <= wr_ext * q_re;
      p_ii <= wi_ext * q_im;
      p_ri <= wr_ext * q_im;
      p_ir <= wi_ext * q_re;
    end
  end

  // sum and round once
  assign sum_re = (PW+2)'(p_rr) - (PW+2)'(p_ii) + RND;
  assign sum_im = (PW+2)'(p_ri) + (PW+2)'(p_ir) + RND;

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      t_re  <= STORE_BITS'(sum_re >>> F);
      t_im  <= STORE_BITS'(sum_im >>> F);
      xj_re <= q_re;
      xj_im <= q_im;
    end
  end

  // store write data select, wraps to store width
  always_comb begin
    case (cmd.wr_sel)
      WSEL_BF_K: begin
        d_re = xj_re - t_re;
        d_im = xj_im - t_im;
      end
      WSEL_BF_J: begin
        d_re = xj_re + t_re;
        d_im = xj_im + t_im;
      end
      default: begin
        d_re = STORE_BITS'(sample_re);
        d_im = STORE_BITS'(sample_im);
      end
    endcase
  end

  assign ram_d = {d_re, d_im};

  // inverse scaling on the way out
  assign out_re = q_re >>> out_shift;
  assign out_im = q_im >>> out_shift;

endmodule

// ===== rtl/fftr2_ctrl.sv =====
`include "assert_macros.svh"

module fftr2_ctrl #(
  parameter int LOG2_MAX_POINTS = fftr2_pkg::LOG2_MAX_POINTS_DEF,
  parameter int TAW             = (LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS - 1 : 1,
  parameter int LW              = $clog2(LOG2_MAX_POINTS + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fftr2_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fftr2_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fftr2_pkg::BIN_BITS-1:0]       bin_index,
  output logic                                 last,
  output fftr2_pkg::dp_cmd_t                   cmd,
  output logic [LOG2_MAX_POINTS-1:0]           rd_addr,
  output logic [LOG2_MAX_POINTS-1:0]           wr_addr,
  output logic [TAW-1:0]                       tw_addr,
  output logic [LW-1:0]                        out_shift
);
  import fftr2_pkg::*;

  localparam int AW = LOG2_MAX_POINTS;
  localparam int CW = LOG2_MAX_POINTS + 1;
  localparam logic [LW-1:0] LG_MAX   = LW'(LOG2_MAX_POINTS);
  localparam logic [LW-1:0] LG_RESET =
    (SIZE_LOG2_RESET > LOG2_MAX_POINTS) ? LW'(LOG2_MAX_POINTS) : LW'(SIZE_LOG2_RESET);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RDK  = 6'b000010,
    ST_RDJ  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_WRK  = 6'b010000,
    ST_WRJ  = 6'b100000
  } state_t;

  state_t                state, state_next;
  logic                  inverse_mode;
  logic [CFG_BITS-1:0]   size_log2;
  logic [LW-1:0]         frame_log2, frame_log2_next;
  logic                  frame_inv, frame_inv_next;
  logic [CW-1:0]         load_count, load_count_next;
  logic [CW-1:0]         read_count, read_count_next;
  logic [LW-1:0]         stage, stage_next;
  logic [AW-1:0]         bfly, bfly_next;
  logic                  out_valid_next;
  logic [BIN_BITS-1:0]   bin_index_next;
  logic                  last_next;

  logic                  accept;
  logic [LW-1:0]         lg_clamp;
  logic [LW-1:0]         lg_eff;
  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         frame_n;
  logic [AW-1:0]         rev_full;
  logic [AW-1:0]         rev_addr;
  logic [AW-1:0]         mask;
  logic [AW-1:0]         j_addr;
  logic [AW-1:0]         k_addr;
  logic [AW-1:0]         tw_full;
  logic                  bfly_last;

  // frame size, clamped to the store
  assign lg_clamp = ({1'b0, size_log2} > 5'(LOG2_MAX_POINTS)) ? LG_MAX : LW'(size_log2);
  assign lg_eff   = (load_count == '0) ? lg_clamp : frame_log2;
  assign n_eff    = CW'(1) << lg_eff;
  assign frame_n  = CW'(1) << frame_log2;

  // bit-reversed load address puts the frame in butterfly order
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = load_count[AW-1-b];
    end
  end
  assign rev_addr = rev_full >> (LG_MAX - lg_eff);

  // butterfly addressing: insert a zero at bit stage-1
  assign mask      = (AW'(1) << (stage - LW'(1))) - AW'(1);
  assign j_addr    = ((bfly & ~mask) << 1) | (bfly & mask);
  assign k_addr    = j_addr | (mask + AW'(1));
  assign tw_full   = (bfly & mask) << (LG_MAX - stage);
  assign tw_addr   = TAW'(tw_full);
  assign bfly_last = {1'b0, bfly} == ((frame_n >> 1) - CW'(1));

  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_shift = frame_inv ? frame_log2 : '0;

  // sequencer
  always_comb begin
    state_next      = state;
    frame_log2_next = frame_log2;
    frame_inv_next  = frame_inv;
    load_count_next = load_count;
    read_count_next = read_count;
    stage_next      = stage;
    bfly_next       = bfly;
    out_valid_next  = out_valid && !out_ready;
    bin_index_next  = bin_index;
    last_next       = last;
    cmd             = '0;
    cmd.wr_sel      = WSEL_LOAD;
    cmd.inv         = frame_inv;
    rd_addr         = read_count[AW-1:0];
    wr_addr         = rev_addr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_LOAD) begin
            if (load_count < n_eff) begin
              cmd.wr_en       = 1'b1;
              load_count_next = load_count + CW'(1);
              frame_log2_next = lg_eff;
              if ((load_count + CW'(1)) == n_eff) begin
                frame_inv_next  = inverse_mode;
                stage_next      = LW'(1);
                bfly_next       = '0;
                read_count_next = '0;
                if (lg_eff != '0) begin
                  state_next = ST_RDK;
                end
              end
            end
          end else if (load_count == frame_n && read_count < frame_n) begin
            cmd.rd_en       = 1'b1;
            out_valid_next  = 1'b1;
            bin_index_next  = BIN_BITS'(read_count);
            last_next       = read_count == (frame_n - CW'(1));
            read_count_next = read_count + CW'(1);
            if ((read_count + CW'(1)) == frame_n) begin
              read_count_next = '0;
              load_count_next = '0;
            end
          end
        end
      end
      ST_RDK: begin
        cmd.rd_en  = 1'b1;
        cmd.tw_en  = 1'b1;
        rd_addr    = k_addr;
        state_next = ST_RDJ;
      end
      ST_RDJ: begin
        cmd.rd_en  = 1'b1;
        cmd.mul_en = 1'b1;
        rd_addr    = j_addr;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_WRK;
      end
      ST_WRK: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_BF_K;
        wr_addr    = k_addr;
        state_next = ST_WRJ;
      end
      ST_WRJ: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_BF_J;
        wr_addr    = j_addr;
        state_next = ST_RDK;
        if (bfly_last) begin
          bfly_next = '0;
          if (stage == frame_log2) begin
            state_next = ST_IDLE;
          end else begin
            stage_next = stage + LW'(1);
          end
        end else begin
          bfly_next = bfly + AW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      inverse_mode <= 1'b0;
      size_log2    <= CFG_BITS'(SIZE_LOG2_RESET);
      frame_log2   <= LG_RESET;
      frame_inv    <= 1'b0;
      load_count   <= '0;
      read_count   <= '0;
      stage        <= LW'(1);
      bfly         <= '0;
      out_valid    <= 1'b0;
      bin_index    <= '0;
      last         <= 1'b0;
    end else begin
      state      <= state_next;
      frame_log2 <= frame_log2_next;
      frame_inv  <= frame_inv_next;
      load_count <= load_count_next;
      read_count <= read_count_next;
      stage      <= stage_next;
      bfly       <= bfly_next;
      out_valid  <= out_valid_next;
      bin_index  <= bin_index_next;
      last       <= last_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INVERSE_MODE: inverse_mode <= cfg_data[0];
          REG_SIZE_LOG2:    size_log2    <= cfg_data;
        endcase
      end
    end
  end

  `CHK_ALWAYS(a_load_bound, clk, rst, load_count <= frame_n)
  `CHK_IMPL(a_busy_full, clk, rst, state != ST_IDLE, load_count == frame_n)
  `CHK_IMPL(a_read_full, clk, rst, read_count != '0, load_count == frame_n)
  `CHK_IMPL(a_stage_range, clk, rst, state != ST_IDLE, stage >= LW'(1) && stage <= frame_log2)
  `CHK_NEXT(a_wrj_next, clk, rst, state == ST_WRJ, state == ST_RDK || state == ST_IDLE)

endmodule

// ===== rtl/fft_radix2_frame_engine.sv =====
// Radix-2 decimation-in-time FFT over frames of 2^size_log2 complex Q1.15
// samples. Each load beat writes one sample (in bit-reversed order, so no
// reorder pass is needed); the load that completes the frame starts the
// butterfly sequencer, which holds in_ready low until every stage is done:
// every butterfly reads two words and writes two words through the single
// read and single write port of the frame store, with one registered
// multiply step and one round-and-add step between. Read beats then return
// bins in natural order at one per cycle while out_ready stays high, each
// bin in the cycle after its read beat; inverse frames are scaled by 1/N at
// read-out. inverse_mode is taken when the frame completes, size_log2 when
// its first sample loads. Loads beyond a full frame and reads before one
// are accepted and dropped.
module fft_radix2_frame_engine #(
  parameter int LOG2_MAX_POINTS = fftr2_pkg::LOG2_MAX_POINTS_DEF,
  parameter int SAMPLE_BITS     = fftr2_pkg::SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS    = fftr2_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [fftr2_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [fftr2_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    action,
  input  logic signed [SAMPLE_BITS-1:0]           sample_re,
  input  logic signed [SAMPLE_BITS-1:0]           sample_im,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [fftr2_pkg::STORE_BITS-1:0] out_re,
  output logic signed [fftr2_pkg::STORE_BITS-1:0] out_im,
  output logic [fftr2_pkg::BIN_BITS-1:0]          bin_index,
  output logic                                    last
);
  import fftr2_pkg::*;

  localparam int TAW = (LOG2_MAX_POINTS > 1) ? LOG2_MAX_POINTS - 1 : 1;
  localparam int LW  = $clog2(LOG2_MAX_POINTS + 1);

  dp_cmd_t                    cmd;
  logic [LOG2_MAX_POINTS-1:0] rd_addr;
  logic [LOG2_MAX_POINTS-1:0] wr_addr;
  logic [TAW-1:0]             tw_addr;
  logic [LW-1:0]              out_shift;

  fftr2_ctrl #(
    .LOG2_MAX_POINTS (LOG2_MAX_POINTS),
    .TAW             (TAW),
    .LW              (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_index (bin_index),
    .last      (last),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .tw_addr   (tw_addr),
    .out_shift (out_shift)
  );

  fftr2_datapath #(
    .LOG2_MAX_POINTS (LOG2_MAX_POINTS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TWIDDLE_BITS    (TWIDDLE_BITS),
    .TAW             (TAW),
    .LW              (LW)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .tw_addr   (tw_addr),
    .out_shift (out_shift),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .out_re    (out_re),
    .out_im    (out_im)
  );

endmodule

// ===== tb/sv/fft_frame_checker.sv =====
module fft_frame_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fftr2_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fftr2_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 action,
  input  logic signed [15:0]                   sample_re,
  input  logic signed [15:0]                   sample_im,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [fftr2_pkg::STORE_BITS-1:0]     out_re,
  input  logic [fftr2_pkg::STORE_BITS-1:0]     out_im,
  input  logic [fftr2_pkg::BIN_BITS-1:0]       bin_index,
  input  logic                                 last,
  output int                                   fail_count,
  output int                                   bins_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import fftr2_pkg::*;

  localparam int MAX_LOG2 = 10;
  localparam longint unsigned PI_Q32_C = 64'd13493037705;

  typedef struct {
    logic [STORE_BITS-1:0] re;
    logic [STORE_BITS-1:0] im;
    logic [BIN_BITS-1:0]   idx;
    logic                  fin;
  } bin_t;

  bin_t   bin_q[$];
  longint frame_re[1 << MAX_LOG2];
  longint frame_im[1 << MAX_LOG2];
  int     loaded;
  int     read_pos;
  int     frame_lg;
  logic   inv_cfg;
  logic [3:0] size_cfg;

  function automatic longint wrap27(longint v);
    return {{37{v[26]}}, v[26:0]};
  endfunction

  // q30 sine and cosine over the first octant
  function automatic void octant_sincos(input longint unsigned r,
                                        output longint s, output longint c);
    longint unsigned x, x2, ts, tc, dv_s, dv_c;
    x  = (r * PI_Q32_C + (64'd1 << 32)) >> 33;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s  = longint'(x);
    c  = longint'(64'd1 << 30);
    for (int n = 1; n <= 6; n++) begin
      dv_s = longint'((2 * n) * (2 * n + 1));
      dv_c = longint'((2 * n - 1) * (2 * n));
      ts = ((ts * x2) >> 30) / dv_s;
      tc = ((tc * x2) >> 30) / dv_c;
      if (n % 2 == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
  endfunction

  // q30 to q1.15 with rounding and saturation
  function automatic longint q15(longint v);
    longint q;
    q = (v + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic void twiddle_at(input logic [31:0] p,
                                     output longint sq, output longint cq);
    longint unsigned r;
    longint s0, c0;
    r = {34'd0, p[29:0]};
    if (r <= (64'd1 << 29)) octant_sincos(r, s0, c0);
    else octant_sincos((64'd1 << 30) - r, c0, s0);
    if (p[30]) begin
      sq = q15(c0);
      cq = q15(-s0);
    end else begin
      sq = q15(s0);
      cq = q15(c0);
    end
  endfunction

  // in-place decimation-in-time transform of the loaded frame
  task automatic run_fft(int lg, logic inv);
    int n, rev, k, stage;
    longint t, ws, wr, wi, tr, ti;
    logic [31:0] ph;
    n = 1 << lg;
    for (int j = 0; j < n; j++) begin
      rev = 0;
      for (int b = 0; b < lg; b++) rev |= ((j >> b) & 1) << (lg - 1 - b);
      if (j < rev) begin
        t = frame_re[j]; frame_re[j] = frame_re[rev]; frame_re[rev] = t;
        t = frame_im[j]; frame_im[j] = frame_im[rev]; frame_im[rev] = t;
      end
    end
    stage = 0;
    for (int h = 1; h < n; h = h * 2) begin
      stage++;
      for (int i = 0; i < h; i++) begin
        ph = 32'(i) << (32 - stage);
        twiddle_at(ph, ws, wr);
        wi = inv ? ws : -ws;
        for (int j = i; j < n; j += 2 * h) begin
          k  = j + h;
          tr = (wr * frame_re[k] - wi * frame_im[k] + 64'sd16384) >>> 15;
          ti = (wr * frame_im[k] + wi * frame_re[k] + 64'sd16384) >>> 15;
          frame_re[k] = wrap27(frame_re[j] - tr);
          frame_im[k] = wrap27(frame_im[j] - ti);
          frame_re[j] = wrap27(frame_re[j] + tr);
          frame_im[j] = wrap27(frame_im[j] + ti);
        end
      end
    end
    if (inv) begin
      for (int j = 0; j < n; j++) begin
        frame_re[j] = frame_re[j] >>> lg;
        frame_im[j] = frame_im[j] >>> lg;
      end
    end
  endtask

  // one accepted input beat
  task automatic predict_beat();
    int   n;
    bin_t b;
    if (action == ACT_LOAD) begin
      if (loaded == 0) frame_lg = (size_cfg > MAX_LOG2) ? MAX_LOG2 : int'(size_cfg);
      n = 1 << frame_lg;
      if (loaded < n) begin
        frame_re[loaded] = longint'(sample_re);
        frame_im[loaded] = longint'(sample_im);
        loaded++;
        if (loaded == n) begin
          run_fft(frame_lg, inv_cfg);
          read_pos = 0;
        end
      end
    end else begin
      n = 1 << frame_lg;
      if (loaded == n && read_pos < n) begin
        b.re  = frame_re[read_pos][STORE_BITS-1:0];
        b.im  = frame_im[read_pos][STORE_BITS-1:0];
        b.idx = BIN_BITS'(read_pos);
        b.fin = (read_pos == n - 1);
        bin_q.push_back(b);
        read_pos++;
        if (read_pos == n) begin
          read_pos = 0;
          loaded   = 0;
        end
      end
    end
  endtask

  // model state, prediction and comparison
  always @(posedge clk) begin
    bin_t b;
    if (rst) begin
      bin_q.delete();
      foreach (frame_re[i]) begin
        frame_re[i] = 0;
        frame_im[i] = 0;
      end
      loaded   = 0;
      read_pos = 0;
      frame_lg = SIZE_LOG2_RESET;
      inv_cfg  = 1'b0;
      size_cfg = 4'(SIZE_LOG2_RESET);
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INVERSE_MODE) inv_cfg = cfg_data[0];
        else if (cfg_index == REG_SIZE_LOG2) size_cfg = cfg_data;
      end
      if (in_valid && in_ready) predict_beat();
      if (out_valid && out_ready) begin
        if (bin_q.size() == 0) begin
          $display("%0t: unexpected bin beat, got re %h im %h bin %0d", $time,
                   out_re, out_im, bin_index);
          fail_count++;
        end else begin
          b = bin_q.pop_front();
          if (out_re !== b.re || out_im !== b.im || bin_index !== b.idx
              || last !== b.fin) begin
            $display("%0t: bin mismatch, expected re %h im %h bin %0d last %b",
                     $time, b.re, b.im, b.idx, b.fin);
            $display("%0t:               got re %h im %h bin %0d last %b",
                     $time, out_re, out_im, bin_index, last);
            fail_count++;
          end
        end
      end
    end
    bins_waiting = bin_q.size();
  end

  initial begin
    fail_count   = 0;
    bins_waiting = 0;
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fftr2_pkg::*;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_INVERSE_MODE;
  logic [CFG_BITS-1:0]          cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         action = ACT_LOAD;
  logic signed [15:0]           sample_re = '0;
  logic signed [15:0]           sample_im = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [STORE_BITS-1:0] out_re;
  logic signed [STORE_BITS-1:0] out_im;
  logic [BIN_BITS-1:0]          bin_index;
  logic                         last;
  int                           fail_count;
  int                           bins_waiting;
  int                           frame_beats;
  int                           burst_left = 0;
  int                           stall_cnt = 0;
  int                           stall_style = 0;

  fft_radix2_frame_engine dut (.*);

  fft_frame_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: free running, sparse, or long stalls
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_style <= $urandom_range(0, 2);
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_cnt % 13 == 0);
    endcase
  end

  // one input beat, in bursts with random gaps
  task automatic send_beat(logic act, logic signed [15:0] re, logic signed [15:0] im);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    action    <= act;
    sample_re <= re;
    sample_im <= im;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every bin is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bins_waiting != 0 || out_valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(int kind);
    int sel;
    sel = $urandom_range(0, 3);
    case (kind)
      1: return (sel == 0) ? -16'sd32768 : (sel == 1) ? 16'sd32767 :
                (sel == 2) ? 16'sd0 : -16'sd1;
      2: return 16'($signed($urandom_range(0, 510)) - 255);
      default: return 16'($urandom);
    endcase
  endfunction

  // full frame: configure, load and read back, with noise beats if noise is set
  task automatic run_frame(logic inv, logic [3:0] size, int kind, bit noise,
                           int change_at, logic [3:0] new_size);
    int lg, n;
    settle();
    write_reg(REG_INVERSE_MODE, {3'b000, inv});
    @(posedge clk);
    write_reg(REG_SIZE_LOG2, size);
    lg = (size > 10) ? 10 : size;
    n  = 1 << lg;
    for (int k = 0; k < n; k++) begin
      if (k == change_at) begin
        settle();
        write_reg(REG_SIZE_LOG2, new_size);
      end
      if (noise && $urandom_range(0, 7) == 0)
        send_beat(ACT_READ, 16'($urandom), 16'($urandom));
      send_beat(ACT_LOAD, pick_sample(kind), pick_sample(kind));
      frame_beats++;
    end
    for (int k = 0; k < n; k++) begin
      if (noise && $urandom_range(0, 7) == 0)
        send_beat(ACT_LOAD, 16'($urandom), 16'($urandom));
      send_beat(ACT_READ, pick_sample(0), pick_sample(0));
      frame_beats++;
    end
    if (noise) send_beat(ACT_READ, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int lg_r;
    frame_beats = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single point, tiny frames, extremes, size change mid-frame
    run_frame(1'b0, 4'd0, 1, 1'b1, -1, 4'd0);
    run_frame(1'b1, 4'd0, 1, 1'b1, -1, 4'd0);
    run_frame(1'b0, 4'd1, 1, 1'b1, -1, 4'd0);
    run_frame(1'b1, 4'd2, 1, 1'b0, 1, 4'd3);
    run_frame(1'b0, 4'd2, 1, 1'b0, -1, 4'd0);

    // oversized size clamps to the largest frame
    run_frame(1'b0, 4'd15, 0, 1'b0, -1, 4'd0);

    // random frames, mostly small
    frame_beats = 0;
    while (frame_beats < 1300) begin
      lg_r = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
      run_frame($urandom_range(0, 1), 4'(lg_r), $urandom_range(0, 2),
                $urandom_range(0, 1), -1, 4'd0);
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("fft_radix2_frame_engine regression: pass");
    else $display("fft_radix2_frame_engine regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("fft_radix2_frame_engine regression: fail");
    $finish;
  end

endmodule
